### rtl/rrb_pkg.sv
// Package for the revision reorder buffer: sizes, message and status codes,
// item structs and the slot-store control struct. No dependencies.
package rrb_pkg;

   localparam int BUFFER_SLOTS = 8;
   localparam int SLOT_IDX_W   = (BUFFER_SLOTS > 1) ? $clog2(BUFFER_SLOTS) : 1;
   localparam int REV_W        = 64;
   localparam int VALUE_W      = 64;

   localparam logic [2:0] MSG_SNAPSHOT     = 3'd0;
   localparam logic [2:0] MSG_FULL_SET     = 3'd1;
   localparam logic [2:0] MSG_PATCH        = 3'd2;
   localparam logic [2:0] MSG_CONNECTED    = 3'd3;
   localparam logic [2:0] MSG_DISCONNECTED = 3'd4;

   localparam logic [2:0] PATH_NOTIFY = 3'd5;
   localparam logic [2:0] PATH_MAX    = 3'd5;

   localparam logic [2:0] ST_UNCHANGED  = 3'd0;
   localparam logic [2:0] ST_CHANGED    = 3'd1;
   localparam logic [2:0] ST_BUFFERED   = 3'd2;
   localparam logic [2:0] ST_NEEDS_SNAP = 3'd3;
   localparam logic [2:0] ST_ERROR      = 3'd4;

   localparam logic KIND_UPDATE = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef struct packed {
      logic [2:0]         req_type;
      logic               payload_ok;
      logic [REV_W-1:0]   msg_revision;
      logic [2:0]         field_path;
      logic [VALUE_W-1:0] field_value;
   } rrb_req_type;

   typedef struct packed {
      logic               kind;
      logic [2:0]         status;
      logic [2:0]         out_path;
      logic [VALUE_W-1:0] out_value;
      logic [REV_W-1:0]   current_revision;
      logic               in_sync;
      logic               last;
   } rrb_rsp_type;

   typedef struct packed {
      logic                  clear_all;
      logic                  free_en;
      logic [SLOT_IDX_W-1:0] free_idx;
      logic                  wr_en;
      logic [SLOT_IDX_W-1:0] wr_idx;
      logic [REV_W-1:0]      wr_rev;
      logic [2:0]            wr_path;
      logic [VALUE_W-1:0]    wr_value;
   } rrb_slot_ctrl_type;

endpackage

### rtl/rrb_cmp.sv
// Shared revision compare unit: one magnitude compare and one equality.
// Depends on rrb_pkg.
module rrb_cmp import rrb_pkg::*; (
   input  logic [REV_W-1:0] cmp_x,
   input  logic [REV_W-1:0] cmp_y,
   input  logic [REV_W-1:0] cmp_z,
   output logic             x_le_y,
   output logic             x_eq_z
);

   assign x_le_y = (cmp_x <= cmp_y);
   assign x_eq_z = (cmp_x == cmp_z);

endmodule

### rtl/rrb_slots.sv
// Early-update slot store: used bits, revision, path and value per slot,
// one scan read port, one write port, one free port. Depends on rrb_pkg.
module rrb_slots import rrb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  rrb_slot_ctrl_type     ctrl,
   input  logic [SLOT_IDX_W-1:0] rd_idx,
   output logic                  rd_used,
   output logic [REV_W-1:0]      rd_rev,
   output logic [2:0]            rd_path,
   output logic [VALUE_W-1:0]    rd_value
);

   logic [BUFFER_SLOTS-1:0] used_ff, used_in;
   logic [REV_W-1:0]        rev_ff   [BUFFER_SLOTS];
   logic [2:0]              path_ff  [BUFFER_SLOTS];
   logic [VALUE_W-1:0]      value_ff [BUFFER_SLOTS];

   always_comb begin
      used_in = used_ff;
      if (ctrl.clear_all) begin
         used_in = '0;
      end else begin
         if (ctrl.free_en) begin
            used_in[ctrl.free_idx] = 1'b0;
         end
         if (ctrl.wr_en) begin
            used_in[ctrl.wr_idx] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         rev_ff[ctrl.wr_idx]   <= ctrl.wr_rev;
         path_ff[ctrl.wr_idx]  <= ctrl.wr_path;
         value_ff[ctrl.wr_idx] <= ctrl.wr_value;
      end
   end

   assign rd_used  = used_ff[rd_idx];
   assign rd_rev   = rev_ff[rd_idx];
   assign rd_path  = path_ff[rd_idx];
   assign rd_value = value_ff[rd_idx];

endmodule

### rtl/revision_reorder_buffer_unit.sv
// Revision reorder buffer top level: sequencer, output register, shared
// compare unit and slot store. Depends on rrb_pkg, rrb_cmp, rrb_slots.
//
// Usage:
//   req_* takes one message item (valid/ready). req_ready is high only when
//   the sequencer is idle; an item is then worked on alone until its final
//   status item has been loaded into the output register.
//   rsp_* gives result items (valid/ready): zero or more applied updates,
//   then one status item with last set.
//   Per item: connect, disconnect, other, errors found at decode and stale updates
//   go straight to the status item; an in-order apply loads one update item first;
//   an update that is stored scans every slot; a snapshot scans all slots once per
//   replayed update and once more, one slot per cycle through the shared compare unit.
//   Result items are held in a single output register; while the receiver
//   stalls the sequencer waits before loading the next one, and the next
//   message can be taken while the final status item waits.
//   Reset (synchronous): revision 0, in sync, all slots free, no item pending.
module revision_reorder_buffer_unit import rrb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  rrb_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rrb_rsp_type rsp_data
);

   typedef enum logic [7:0] {
      S_IDLE       = 8'b0000_0001,
      S_DECODE     = 8'b0000_0010,
      S_STORE      = 8'b0000_0100,
      S_STORE_WR   = 8'b0000_1000,
      S_REPLAY     = 8'b0001_0000,
      S_REPLAY_END = 8'b0010_0000,
      S_APPLY      = 8'b0100_0000,
      S_STATUS     = 8'b1000_0000
   } state_type;

   state_type             state_ff, state_in;
   rrb_req_type           req_ff, req_in;
   logic [REV_W-1:0]      held_ff, held_in;
   logic [REV_W-1:0]      held_plus_ff, held_plus_in;
   logic                  resync_ff, resync_in;
   logic [SLOT_IDX_W-1:0] idx_ff, idx_in;
   logic [2:0]            status_ff, status_in;
   logic                  dup_ff, dup_in;
   logic                  free_found_ff, free_found_in;
   logic [SLOT_IDX_W-1:0] free_idx_ff, free_idx_in;
   logic                  next_found_ff, next_found_in;
   logic [SLOT_IDX_W-1:0] next_idx_ff, next_idx_in;
   logic [2:0]            next_path_ff, next_path_in;
   logic [VALUE_W-1:0]    next_value_ff, next_value_in;
   logic                  gap_ff, gap_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rrb_rsp_type           rsp_ff, rsp_in;

   rrb_slot_ctrl_type     slot_ctrl;
   logic                  rd_used;
   logic [REV_W-1:0]      rd_rev;
   logic [2:0]            rd_path;
   logic [VALUE_W-1:0]    rd_value;

   logic [REV_W-1:0]      cmp_x, cmp_z;
   logic                  x_le_y, x_eq_z;
   logic                  out_free, last_idx, upd_bad;

   rrb_cmp u_cmp (
      .cmp_x  (cmp_x),
      .cmp_y  (held_ff),
      .cmp_z  (cmp_z),
      .x_le_y (x_le_y),
      .x_eq_z (x_eq_z)
   );

   rrb_slots u_slots (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (slot_ctrl),
      .rd_idx   (idx_ff),
      .rd_used  (rd_used),
      .rd_rev   (rd_rev),
      .rd_path  (rd_path),
      .rd_value (rd_value)
   );

   assign cmp_x    = (state_ff == S_DECODE) ? req_ff.msg_revision : rd_rev;
   assign cmp_z    = (state_ff == S_STORE) ? req_ff.msg_revision : held_plus_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign last_idx = (idx_ff == SLOT_IDX_W'(BUFFER_SLOTS - 1));
   assign upd_bad  = !req_ff.payload_ok || (req_ff.field_path > PATH_MAX) ||
                     ((req_ff.req_type == MSG_PATCH) && (req_ff.field_path == PATH_NOTIFY));

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      held_in       = held_ff;
      held_plus_in  = held_plus_ff;
      resync_in     = resync_ff;
      idx_in        = idx_ff;
      status_in     = status_ff;
      dup_in        = dup_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      next_found_in = next_found_ff;
      next_idx_in   = next_idx_ff;
      next_path_in  = next_path_ff;
      next_value_in = next_value_ff;
      gap_in        = gap_ff;
      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_in        = rsp_ff;
      slot_ctrl     = '0;
      slot_ctrl.wr_idx   = free_idx_ff;
      slot_ctrl.wr_rev   = req_ff.msg_revision;
      slot_ctrl.wr_path  = req_ff.field_path;
      slot_ctrl.wr_value = req_ff.field_value;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            status_in = ST_UNCHANGED;
            state_in  = S_STATUS;
            idx_in    = '0;
            dup_in        = 1'b0;
            free_found_in = 1'b0;
            next_found_in = 1'b0;
            gap_in        = 1'b0;
            case (req_ff.req_type)
               MSG_SNAPSHOT: begin
                  if (!req_ff.payload_ok) begin
                     status_in = ST_ERROR;
                  end else begin
                     held_in      = req_ff.msg_revision;
                     held_plus_in = req_ff.msg_revision + REV_W'(1);
                     state_in     = S_REPLAY;
                  end
               end
               MSG_FULL_SET, MSG_PATCH: begin
                  if (upd_bad) begin
                     status_in = ST_ERROR;
                  end else if (x_le_y) begin
                     status_in = ST_UNCHANGED;
                  end else if (resync_ff) begin
                     status_in = ST_BUFFERED;
                     state_in  = S_STORE;
                  end else if (!x_eq_z) begin
                     resync_in = 1'b1;
                     status_in = ST_NEEDS_SNAP;
                     state_in  = S_STORE;
                  end else begin
                     held_in      = req_ff.msg_revision;
                     held_plus_in = req_ff.msg_revision + REV_W'(1);
                     state_in     = S_APPLY;
                  end
               end
               MSG_CONNECTED: begin
                  resync_in = 1'b1;
               end
               MSG_DISCONNECTED: begin
                  resync_in           = 1'b0;
                  slot_ctrl.clear_all = 1'b1;
               end
               default: begin
                  status_in = ST_UNCHANGED;
               end
            endcase
         end
         S_STORE: begin
            if (rd_used && x_eq_z) begin
               dup_in = 1'b1;
            end
            if (!rd_used && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = idx_ff;
            end
            if (last_idx) begin
               state_in = S_STORE_WR;
            end else begin
               idx_in = idx_ff + SLOT_IDX_W'(1);
            end
         end
         S_STORE_WR: begin
            if (!dup_ff) begin
               if (free_found_ff) begin
                  slot_ctrl.wr_en = 1'b1;
               end else begin
                  status_in = ST_ERROR;
               end
            end
            state_in = S_STATUS;
         end
         S_REPLAY: begin
            if (rd_used) begin
               if (x_le_y) begin
                  slot_ctrl.free_en  = 1'b1;
                  slot_ctrl.free_idx = idx_ff;
               end else if (x_eq_z) begin
                  next_found_in = 1'b1;
                  next_idx_in   = idx_ff;
                  next_path_in  = rd_path;
                  next_value_in = rd_value;
               end else begin
                  gap_in = 1'b1;
               end
            end
            if (last_idx) begin
               state_in = S_REPLAY_END;
            end else begin
               idx_in = idx_ff + SLOT_IDX_W'(1);
            end
         end
         S_REPLAY_END: begin
            if (!next_found_ff) begin
               resync_in = gap_ff;
               status_in = gap_ff ? ST_NEEDS_SNAP : ST_CHANGED;
               state_in  = S_STATUS;
            end else if (out_free) begin
               slot_ctrl.free_en  = 1'b1;
               slot_ctrl.free_idx = next_idx_ff;
               held_in      = held_plus_ff;
               held_plus_in = held_plus_ff + REV_W'(1);
               rsp_valid_in = 1'b1;
               rsp_in.kind             = KIND_UPDATE;
               rsp_in.status           = ST_CHANGED;
               rsp_in.out_path         = next_path_ff;
               rsp_in.out_value        = next_value_ff;
               rsp_in.current_revision = held_plus_ff;
               rsp_in.in_sync          = !resync_ff;
               rsp_in.last             = 1'b0;
               idx_in        = '0;
               next_found_in = 1'b0;
               gap_in        = 1'b0;
               state_in      = S_REPLAY;
            end
         end
         S_APPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.kind             = KIND_UPDATE;
               rsp_in.status           = ST_CHANGED;
               rsp_in.out_path         = req_ff.field_path;
               rsp_in.out_value        = req_ff.field_value;
               rsp_in.current_revision = held_ff;
               rsp_in.in_sync          = !resync_ff;
               rsp_in.last             = 1'b0;
               status_in = ST_CHANGED;
               state_in  = S_STATUS;
            end
         end
         S_STATUS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.kind             = KIND_STATUS;
               rsp_in.status           = status_ff;
               rsp_in.out_path         = '0;
               rsp_in.out_value        = '0;
               rsp_in.current_revision = held_ff;
               rsp_in.in_sync          = !resync_ff;
               rsp_in.last             = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         held_ff       <= '0;
         held_plus_ff  <= REV_W'(1);
         resync_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_ff       <= held_in;
         held_plus_ff  <= held_plus_in;
         resync_ff     <= resync_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      idx_ff        <= idx_in;
      status_ff     <= status_in;
      dup_ff        <= dup_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      next_found_ff <= next_found_in;
      next_idx_ff   <= next_idx_in;
      next_path_ff  <= next_path_in;
      next_value_ff <= next_value_in;
      gap_ff        <= gap_in;
      rsp_ff        <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("accepted a message while one is in progress");

   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.kind == KIND_STATUS)) |-> rsp_data.last)
      else $error("status item without last");

   a_update_changed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.kind == KIND_UPDATE)) |->
      ((rsp_data.status == ST_CHANGED) && !rsp_data.last))
      else $error("applied update item with bad status or last");

   a_needs_snap_out_of_sync: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.kind == KIND_STATUS) && (rsp_data.status == ST_NEEDS_SNAP))
      |-> !rsp_data.in_sync)
      else $error("needs-snapshot status while in sync");

endmodule

### tb/revision_reorder_buffer_unit_tb.sv
// Self-checking testbench for revision_reorder_buffer_unit: a directed stimulus table,
// then random message streams, checked against a shadow copy of the revision/slot state.
// Depends on rrb_pkg and the revision_reorder_buffer_unit RTL.
module revision_reorder_buffer_unit_tb;
   import rrb_pkg::*;

   localparam logic [2:0] MSG_OTHER   = 3'd5;
   localparam logic [2:0] MSG_SPARE_A = 3'd6;
   localparam logic [2:0] MSG_SPARE_B = 3'd7;

   localparam logic [2:0] PATH_TEMP    = 3'd0;
   localparam logic [2:0] PATH_TITLE   = 3'd2;
   localparam logic [2:0] PATH_PLAYING = 3'd3;
   localparam logic [2:0] PATH_STEPS   = 3'd4;
   localparam logic [2:0] PATH_BAD_LO  = 3'd6;
   localparam logic [2:0] PATH_BAD_HI  = 3'd7;

   localparam logic [63:0] ONES = '1;
   localparam int IDLE_LIMIT    = 2000;
   localparam int RANDOM_ITEMS  = 250;
   localparam int HOLD_POINT    = 140;
   localparam int DRAIN_CYCLES  = 40;

   typedef struct {
      rrb_req_type msg;
      bit          typed;
      rrb_rsp_type want;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   rrb_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rrb_rsp_type rsp_data;

   rrb_rsp_type  due_items[$];
   plan_row_type plan_rows[$];
   int           error_count = 0;
   int           burst_left = 0;
   logic [7:0]   stall_phase = '0;

   // shadow state
   logic [63:0] shadow_rev = '0;
   bit          shadow_resync = 1'b0;
   bit          slot_busy[BUFFER_SLOTS];
   logic [63:0] slot_rev_q[BUFFER_SLOTS];
   logic [2:0]  slot_path_q[BUFFER_SLOTS];
   logic [63:0] slot_val_q[BUFFER_SLOTS];

   revision_reorder_buffer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void queue_item(logic kind, logic [2:0] st, logic [2:0] path,
                                      logic [63:0] value, logic last);
      rrb_rsp_type r;
      r.kind             = kind;
      r.status           = st;
      r.out_path         = path;
      r.out_value        = value;
      r.current_revision = shadow_rev;
      r.in_sync          = !shadow_resync;
      r.last             = last;
      due_items.push_back(r);
   endfunction

   function automatic bit stash_update(logic [63:0] rev, logic [2:0] path, logic [63:0] value);
      for (int i = 0; i < BUFFER_SLOTS; i++)
         if (slot_busy[i] && slot_rev_q[i] == rev) return 1'b1;
      for (int i = 0; i < BUFFER_SLOTS; i++) begin
         if (!slot_busy[i]) begin
            slot_busy[i]   = 1'b1;
            slot_rev_q[i]  = rev;
            slot_path_q[i] = path;
            slot_val_q[i]  = value;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void replay_slots();
      int          next_slot;
      bit          gap;
      logic [63:0] succ;
      while (1'b1) begin
         next_slot = -1;
         gap       = 1'b0;
         succ      = shadow_rev + 64'd1;
         for (int i = 0; i < BUFFER_SLOTS; i++) begin
            if (slot_busy[i]) begin
               if (slot_rev_q[i] <= shadow_rev) slot_busy[i] = 1'b0;
               else if (slot_rev_q[i] == succ) next_slot = i;
               else gap = 1'b1;
            end
         end
         if (next_slot < 0) begin
            shadow_resync = gap;
            return;
         end
         shadow_rev = slot_rev_q[next_slot];
         slot_busy[next_slot] = 1'b0;
         queue_item(KIND_UPDATE, ST_CHANGED, slot_path_q[next_slot], slot_val_q[next_slot],
                    1'b0);
      end
   endfunction

   function automatic void apply_message(rrb_req_type m);
      logic [2:0] st;
      st = ST_UNCHANGED;
      case (m.req_type)
         MSG_SNAPSHOT: begin
            if (!m.payload_ok) st = ST_ERROR;
            else begin
               shadow_rev = m.msg_revision;
               replay_slots();
               st = shadow_resync ? ST_NEEDS_SNAP : ST_CHANGED;
            end
         end
         MSG_FULL_SET, MSG_PATCH: begin
            if (!m.payload_ok || m.field_path > PATH_MAX ||
                (m.req_type == MSG_PATCH && m.field_path == PATH_NOTIFY))
               st = ST_ERROR;
            else if (m.msg_revision <= shadow_rev)
               st = ST_UNCHANGED;
            else if (shadow_resync)
               st = stash_update(m.msg_revision, m.field_path, m.field_value) ?
                    ST_BUFFERED : ST_ERROR;
            else if (m.msg_revision > shadow_rev + 64'd1) begin
               shadow_resync = 1'b1;
               st = stash_update(m.msg_revision, m.field_path, m.field_value) ?
                    ST_NEEDS_SNAP : ST_ERROR;
            end else begin
               shadow_rev = m.msg_revision;
               queue_item(KIND_UPDATE, ST_CHANGED, m.field_path, m.field_value, 1'b0);
               st = ST_CHANGED;
            end
         end
         MSG_CONNECTED: shadow_resync = 1'b1;
         MSG_DISCONNECTED: begin
            shadow_resync = 1'b0;
            for (int i = 0; i < BUFFER_SLOTS; i++) slot_busy[i] = 1'b0;
         end
         default: ;
      endcase
      queue_item(KIND_STATUS, st, '0, '0, 1'b1);
   endfunction

   function automatic rrb_req_type make_msg(logic [2:0] kind, logic ok, logic [63:0] rev,
                                            logic [2:0] path, logic [63:0] value);
      rrb_req_type m;
      m.req_type     = kind;
      m.payload_ok   = ok;
      m.msg_revision = rev;
      m.field_path   = path;
      m.field_value  = value;
      return m;
   endfunction

   function automatic void add_checked(rrb_req_type m);
      plan_row_type row;
      row.msg   = m;
      row.typed = 1'b0;
      row.want  = '0;
      plan_rows.push_back(row);
   endfunction

   function automatic void add_typed(rrb_req_type m, logic [2:0] st, logic [63:0] rev,
                                     logic sync);
      plan_row_type row;
      row.msg   = m;
      row.typed = 1'b1;
      row.want  = '{kind: KIND_STATUS, status: st, out_path: '0, out_value: '0,
                    current_revision: rev, in_sync: sync, last: 1'b1};
      plan_rows.push_back(row);
   endfunction

   function automatic rrb_req_type pick_message();
      rrb_req_type m;
      int unsigned sel;
      sel = $urandom_range(0, 99);
      m = make_msg($urandom_range(0, 1) ? MSG_FULL_SET : MSG_PATCH,
                   $urandom_range(0, 19) != 0, shadow_rev + 64'd1, '0,
                   {$urandom, $urandom});
      m.field_path = (m.req_type == MSG_PATCH) ? 3'($urandom_range(0, PATH_MAX - 1))
                                               : 3'($urandom_range(0, PATH_MAX));
      if (sel < 38) ;
      else if (sel < 62) m.msg_revision = shadow_rev + $urandom_range(2, 11);
      else if (sel < 70) m.msg_revision = shadow_rev + $urandom_range(1, 4);
      else if (sel < 78) begin
         m.req_type = MSG_SNAPSHOT;
         case ($urandom_range(0, 9))
            0:       m.msg_revision = ONES - $urandom_range(0, 15);
            1, 2, 3: m.msg_revision = {$urandom, $urandom};
            default: m.msg_revision = shadow_rev + $urandom_range(0, 3);
         endcase
      end else if (sel < 82) m.req_type = MSG_CONNECTED;
      else if (sel < 86) m.req_type = MSG_DISCONNECTED;
      else if (sel < 90) m.msg_revision = shadow_rev - $urandom_range(0, 3);
      else
         m = make_msg(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                      {$urandom, $urandom}, 3'($urandom_range(0, 7)), {$urandom, $urandom});
      return m;
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      error_count++;
   endtask

   task automatic check_result(rrb_rsp_type got);
      rrb_rsp_type want;
      if (due_items.size() == 0) begin
         report("item with nothing pending", 64'(got.status), '0);
         return;
      end
      want = due_items.pop_front();
      if (got.kind !== want.kind) report("kind", 64'(got.kind), 64'(want.kind));
      if (got.status !== want.status)
         report("status", 64'(got.status), 64'(want.status));
      if (got.out_path !== want.out_path)
         report("out_path", 64'(got.out_path), 64'(want.out_path));
      if (got.out_value !== want.out_value) report("out_value", got.out_value, want.out_value);
      if (got.current_revision !== want.current_revision)
         report("current_revision", got.current_revision, want.current_revision);
      if (got.in_sync !== want.in_sync)
         report("in_sync", 64'(got.in_sync), 64'(want.in_sync));
      if (got.last !== want.last) report("last", 64'(got.last), 64'(want.last));
   endtask

   task automatic deliver(rrb_req_type m);
      req_data  <= m;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      apply_message(m);
   endtask

   task automatic pace();
      if (burst_left > 0) burst_left--;
      else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 11);
      end
   endtask

   always @(posedge clock) begin
      stall_phase <= stall_phase + 8'd1;
      case (stall_phase[7:6])
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= 1'($urandom_range(0, 1));
         2'd2: rsp_ready <= (stall_phase[1:0] == 2'd0);
         default: rsp_ready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready) check_result(rsp_data);

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("revision_reorder_buffer_unit_tb: errors");
      $finish;
   end

   initial begin
      rrb_req_type m;
      int counted;
      int idx;
      for (int i = 0; i < BUFFER_SLOTS; i++) slot_busy[i] = 1'b0;

      add_typed(make_msg(MSG_OTHER, 1'b1, ONES, PATH_BAD_HI, ONES), ST_UNCHANGED, '0, 1'b1);
      add_typed(make_msg(MSG_SPARE_A, 1'b0, '0, PATH_TEMP, '0), ST_UNCHANGED, '0, 1'b1);
      add_typed(make_msg(MSG_SPARE_B, 1'b1, ONES, PATH_BAD_HI, ONES), ST_UNCHANGED, '0, 1'b1);
      add_typed(make_msg(MSG_SNAPSHOT, 1'b0, ONES, PATH_TEMP, '0), ST_ERROR, '0, 1'b1);
      add_typed(make_msg(MSG_FULL_SET, 1'b0, 64'd1, PATH_TEMP, ONES), ST_ERROR, '0, 1'b1);
      add_typed(make_msg(MSG_PATCH, 1'b1, 64'd1, PATH_NOTIFY, ONES), ST_ERROR, '0, 1'b1);
      add_typed(make_msg(MSG_FULL_SET, 1'b1, 64'd1, PATH_BAD_LO, '0), ST_ERROR, '0, 1'b1);
      add_typed(make_msg(MSG_PATCH, 1'b1, 64'd1, PATH_BAD_HI, '0), ST_ERROR, '0, 1'b1);
      add_typed(make_msg(MSG_FULL_SET, 1'b1, '0, PATH_TEMP, ONES), ST_UNCHANGED, '0, 1'b1);
      add_checked(make_msg(MSG_FULL_SET, 1'b1, 64'd1, PATH_NOTIFY, ONES));
      add_checked(make_msg(MSG_PATCH, 1'b1, 64'd1, PATH_TEMP, '0));
      // skip ahead, then a duplicate and fill-ins while resyncing
      add_checked(make_msg(MSG_PATCH, 1'b1, 64'd3, PATH_TITLE, 64'hA5A5_5A5A_0F0F_F0F0));
      add_checked(make_msg(MSG_PATCH, 1'b1, 64'd3, PATH_TITLE, '0));
      add_checked(make_msg(MSG_FULL_SET, 1'b1, 64'd2, PATH_STEPS, '0));
      add_checked(make_msg(MSG_FULL_SET, 1'b1, 64'd5, PATH_PLAYING, 64'h1234_5678_9ABC_DEF0));
      add_checked(make_msg(MSG_SNAPSHOT, 1'b1, 64'd1, PATH_TEMP, '0));
      add_checked(make_msg(MSG_CONNECTED, 1'b0, ONES, PATH_BAD_HI, ONES));
      add_checked(make_msg(MSG_DISCONNECTED, 1'b0, ONES, PATH_BAD_HI, ONES));
      // revision wrap at the top of the range
      add_checked(make_msg(MSG_SNAPSHOT, 1'b1, ONES - 64'd1, PATH_TEMP, '0));
      add_checked(make_msg(MSG_PATCH, 1'b1, ONES, PATH_TEMP, ONES));
      add_checked(make_msg(MSG_FULL_SET, 1'b1, '0, PATH_TITLE, ONES));
      add_checked(make_msg(MSG_FULL_SET, 1'b1, ONES, PATH_TITLE, ONES));
      add_checked(make_msg(MSG_SNAPSHOT, 1'b1, '0, PATH_TEMP, '0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (plan_rows[i]) begin
         deliver(plan_rows[i].msg);
         if (plan_rows[i].typed) begin
            void'(due_items.pop_back());
            due_items.push_back(plan_rows[i].want);
         end
         pace();
      end

      counted = 0;
      idx     = 0;
      while (counted < RANDOM_ITEMS) begin
         if (idx == HOLD_POINT) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (due_items.size() != 0);
         end
         m = pick_message();
         deliver(m);
         pace();
         if (m.req_type <= MSG_DISCONNECTED) counted++;
         idx++;
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (due_items.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("revision_reorder_buffer_unit_tb: clean");
      else
         $display("revision_reorder_buffer_unit_tb: errors");
      $finish;
   end

endmodule
